@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the resampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property checked on every rising edge outside reset.
`define SPR_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

// An implication checked in the same cycle outside reset.
`define SPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

`else

`define SPR_ASSERT(lbl, clk, rstn, prop, msg)
`define SPR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/spr_pkg.sv @@
package spr_pkg;

	localparam int WEIGHT_BITS = 16;
	localparam int OFFSET_BITS = 16;
	localparam int THR_W       = 8;
	localparam int INDEX_W     = 10;

	localparam logic [THR_W-1:0] THR_RESET = 8'd128;

	typedef logic [1:0] action_t;

	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_START = 2'd1;
	localparam action_t ACT_FETCH = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_INDEX  = 1'b1;

	// Outcome of the effective-count check.
	typedef struct packed {
		logic done;
		logic walk;
	} spr_neff_res_t;

endpackage

@@ hw/rtl/spr_cum_mem.sv @@
module spr_cum_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 26,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/spr_neff.sv @@
module spr_neff #(
	parameter int CNT_W = 11,
	parameter int CUM_W = 26,
	parameter int SQ_W  = 42
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [CUM_W-1:0]            total,
	input  logic [SQ_W-1:0]             sumsq,
	input  logic [CNT_W-1:0]            count,
	input  logic [spr_pkg::THR_W-1:0]   threshold,
	output spr_pkg::spr_neff_res_t      res
);
	import spr_pkg::*;

	localparam int TC_W  = THR_W + CNT_W;
	localparam int LO_W  = (SQ_W + 1) / 2;
	localparam int HI_W  = SQ_W - LO_W;
	localparam int TSQ_W = 2 * CUM_W;
	localparam int L_W   = TSQ_W + 8;
	localparam int R_W   = TC_W + SQ_W;
	localparam int CMP_W = (L_W > R_W) ? L_W : R_W;

	logic              valid_s1, valid_s2;
	logic [TSQ_W-1:0]  tsq_s1, tsq_s2;
	logic [TC_W-1:0]   tc_s1;
	logic [SQ_W-1:0]   sq_s1;
	logic [TC_W+LO_W-1:0] plo_s2;
	logic [TC_W+HI_W-1:0] phi_s2;
	logic [CMP_W-1:0]  lhs, rhs;
	logic              done_q, walk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= go;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	// The threshold-count product is split against the two halves of the
	// square sum so that no single multiplier grows too wide.
	always_ff @(posedge clk) begin
		tsq_s1 <= TSQ_W'(total) * TSQ_W'(total);
		tc_s1  <= TC_W'(threshold) * TC_W'(count);
		sq_s1  <= sumsq;
		tsq_s2 <= tsq_s1;
		plo_s2 <= (TC_W+LO_W)'(tc_s1) * (TC_W+LO_W)'(sq_s1[LO_W-1:0]);
		phi_s2 <= (TC_W+HI_W)'(tc_s1) * (TC_W+HI_W)'(sq_s1[SQ_W-1:LO_W]);
		walk_q <= !(lhs > rhs);
	end

	assign lhs = CMP_W'({tsq_s2, 8'd0});
	assign rhs = (CMP_W'(phi_s2) << LO_W) + CMP_W'(plo_s2);

	assign res.done = done_q;
	assign res.walk = walk_q;

endmodule

@@ hw/rtl/systematic_particle_resampler_top.sv @@
// Loads are accepted back to back and give no reply; an identity or error reply passes through the emit state.
// A start with a loaded set waits for the result of the three-stage effective-count check
// before its reply is emitted. A walking fetch steps through the store entry by entry,
// as each step reads the store, multiplies and compares in turn.
// Output stalls delay every reply. Asynchronous reset clears counts, sums and flags and
// sets the threshold to 128; the cumulative store is not cleared and is only read below count.
module systematic_particle_resampler_top #(
	parameter int MAX_PARTICLES = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [spr_pkg::WEIGHT_BITS-1:0]   weight,
	input  logic [spr_pkg::OFFSET_BITS-1:0]   stride_offset,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              reply_kind,
	output logic                              resampled,
	output logic [spr_pkg::INDEX_W-1:0]       source_index,
	output logic                              last,
	output logic                              error,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spr_pkg::THR_W-1:0]         cfg_data
);
	import spr_pkg::*;

	`include "assert_macros.svh"

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int CUM_W = WEIGHT_BITS + IDX_W;
	localparam int SQ_W  = 2 * WEIGHT_BITS + IDX_W;
	localparam int TGT_W = OFFSET_BITS + CNT_W;
	localparam int CP_W  = CUM_W + CNT_W;
	localparam int TH_W  = TGT_W + CUM_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEFF = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_CMP  = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]        state_q;
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  count_q, slot_q;
	logic [CUM_W-1:0]  total_q;
	logic [SQ_W-1:0]   sq_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              started_q, walk_mode_q;

	logic              p_kind_q, p_res_q, p_last_q, p_err_q;
	logic [IDX_W-1:0]  p_idx_q;
	logic              out_valid_q, out_kind_q, out_res_q, out_last_q, out_err_q;
	logic [IDX_W-1:0]  out_idx_q;

	logic [TH_W-1:0]   th_q;
	logic [CP_W-1:0]   cprod_q;

	logic                       take;
	logic                       out_free;
	logic [CNT_W-1:0]           base_cnt;
	logic [CUM_W-1:0]           base_total, new_total;
	logic [SQ_W-1:0]            base_sq;
	logic [2*WEIGHT_BITS-1:0]   wsq;
	logic                       load_en;
	logic                       neff_go;
	spr_neff_res_t              neff_res;
	logic [CUM_W-1:0]           rd_data;
	logic                       advance;
	logic                       fetch_bad;
	logic                       fetch_ident;
	logic                       slot_last;

	assign take      = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// A load that follows a start begins a new set.
	assign base_cnt   = started_q ? '0 : count_q;
	assign base_total = started_q ? '0 : total_q;
	assign base_sq    = started_q ? '0 : sq_q;
	assign wsq        = weight * weight;
	assign new_total  = base_total + CUM_W'(weight);
	assign load_en    = take && (action == ACT_LOAD) && (base_cnt < CNT_W'(MAX_PARTICLES));

	assign neff_go     = take && (action == ACT_START) && (count_q != '0);
	assign fetch_bad   = !started_q || (slot_q >= count_q);
	assign fetch_ident = (action == ACT_FETCH) && !fetch_bad && !walk_mode_q;
	assign slot_last   = (slot_q + CNT_W'(1)) == count_q;
	assign advance     = ((CNT_W'(ptr_q) + CNT_W'(1)) < count_q)
		&& (th_q > {cprod_q, {OFFSET_BITS{1'b0}}});

	spr_cum_mem #(
		.DEPTH (MAX_PARTICLES),
		.WIDTH (CUM_W),
		.AW    (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (load_en),
		.wr_addr (IDX_W'(base_cnt)),
		.wr_data (new_total),
		.rd_en   (state_q == ST_RD),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	spr_neff #(
		.CNT_W (CNT_W),
		.CUM_W (CUM_W),
		.SQ_W  (SQ_W)
	) u_neff (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (neff_go),
		.total     (total_q),
		.sumsq     (sq_q),
		.count     (count_q),
		.threshold (thr_q),
		.res       (neff_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			count_q     <= '0;
			total_q     <= '0;
			sq_q        <= '0;
			ptr_q       <= '0;
			slot_q      <= '0;
			tgt_q       <= '0;
			started_q   <= 1'b0;
			walk_mode_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (action)
							ACT_LOAD: begin
								if (started_q) begin
									started_q   <= 1'b0;
									walk_mode_q <= 1'b0;
								end
								if (load_en) begin
									count_q <= base_cnt + CNT_W'(1);
									total_q <= new_total;
									sq_q    <= base_sq + SQ_W'(wsq);
								end
							end
							ACT_START: begin
								if (count_q == '0) begin
									state_q <= ST_EMIT;
								end else begin
									ptr_q   <= '0;
									slot_q  <= '0;
									tgt_q   <= TGT_W'(stride_offset);
									state_q <= ST_NEFF;
								end
							end
							ACT_FETCH: begin
								if (fetch_bad || !walk_mode_q) begin
									state_q <= ST_EMIT;
									if (!fetch_bad) begin
										slot_q <= slot_q + CNT_W'(1);
										tgt_q  <= tgt_q + (TGT_W'(1) << OFFSET_BITS);
									end
								end else begin
									state_q <= ST_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_NEFF: begin
					if (neff_res.done) begin
						started_q   <= 1'b1;
						walk_mode_q <= neff_res.walk && (total_q != '0);
						state_q     <= ST_EMIT;
					end
				end
				ST_RD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (advance) begin
						ptr_q   <= ptr_q + IDX_W'(1);
						state_q <= ST_RD;
					end else begin
						slot_q  <= slot_q + CNT_W'(1);
						tgt_q   <= tgt_q + (TGT_W'(1) << OFFSET_BITS);
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk products are registered here; reply payload is staged in the pending
	// registers and copied to the output register once it is free.
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			th_q <= TH_W'(tgt_q) * TH_W'(total_q);
		end
		if (state_q == ST_MUL) begin
			cprod_q <= CP_W'(rd_data) * CP_W'(count_q);
		end
		if (state_q == ST_IDLE && take) begin
			p_kind_q <= (action == ACT_FETCH) ? KIND_INDEX : KIND_STATUS;
			p_res_q  <= 1'b0;
			p_idx_q  <= fetch_ident ? IDX_W'(slot_q) : '0;
			p_last_q <= fetch_ident ? slot_last : 1'b0;
			p_err_q  <= (action == ACT_START) ? (count_q == '0) : fetch_bad;
		end
		if (state_q == ST_NEFF && neff_res.done) begin
			p_res_q <= neff_res.walk && (total_q != '0);
		end
		if (state_q == ST_CMP && !advance) begin
			p_res_q  <= 1'b1;
			p_idx_q  <= ptr_q;
			p_last_q <= slot_last;
		end
		if (state_q == ST_EMIT && out_free) begin
			out_kind_q <= p_kind_q;
			out_res_q  <= p_res_q;
			out_idx_q  <= p_idx_q;
			out_last_q <= p_last_q;
			out_err_q  <= p_err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign reply_kind   = out_kind_q;
	assign resampled    = out_res_q;
	assign source_index = INDEX_W'(out_idx_q);
	assign last         = out_last_q;
	assign error        = out_err_q;

	`SPR_ASSERT_IMP(a_ptr_in_set, clk, arst_n, started_q, CNT_W'(ptr_q) < count_q, "walk pointer beyond loaded set")
	`SPR_ASSERT_IMP(a_slot_in_set, clk, arst_n, started_q, slot_q <= count_q, "slot counter beyond loaded set")
	`SPR_ASSERT_IMP(a_neff_timing, clk, arst_n, neff_res.done, state_q == ST_NEFF, "effective-count result outside start")
	`SPR_ASSERT(a_no_drop, clk, arst_n, (state_q == ST_EMIT && !out_free) |=> (state_q == ST_EMIT), "pending reply lost")

endmodule
